FILE: rtl/voc_frame_crc_checker_assert.svh
// assertion macros for the voc frame crc checker
// expects clk and rst in the scope of use
`ifndef VOC_FRAME_CRC_CHECKER_ASSERT_SVH
`define VOC_FRAME_CRC_CHECKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VFCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define VFCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vfcc_pkg.sv
// shared types, constants and crc function for the voc frame crc checker
// no dependencies
package vfcc_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  localparam int unsigned POS_W = 3;
  localparam logic [POS_W-1:0] POS_STATUS = 3'd0;
  localparam logic [POS_W-1:0] CRC_SPAN   = 3'd4;  // position of the crc byte
  localparam logic [POS_W-1:0] FRAME_LEN  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [23:0] voc_ppb;
    logic        crc_ok;
    logic        data_ready;
    logic [7:0]  status_byte;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

  // crc-8 over one byte, msb first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/vfcc_frame_track.sv
// frame position, running crc and value assembly for one byte per transfer
// depends on vfcc_pkg
module vfcc_frame_track (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  vfcc_pkg::in_t              in_data,
  output vfcc_pkg::res_t             res,
  output logic [vfcc_pkg::POS_W-1:0] pos
);
  import vfcc_pkg::*;

  logic [POS_W-1:0] pos_eff;
  logic [7:0]       crc_acc;
  logic [7:0]       held_status;
  logic [23:0]      value_acc;
  logic             ok;
  logic             ready;

  assign pos_eff = (in_data.frame_start || pos >= FRAME_LEN) ? POS_STATUS : pos;
  assign ok      = (crc_acc == in_data.data_byte);
  assign ready   = ~held_status[0];

  always_comb begin
    res.valid            = take && (pos_eff == CRC_SPAN);
    res.data.voc_ppb     = (ok && ready) ? value_acc : 24'd0;
    res.data.crc_ok      = ok;
    res.data.data_ready  = ready;
    res.data.status_byte = held_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_STATUS;
      crc_acc     <= CRC_INIT;
      held_status <= 8'd0;
      value_acc   <= 24'd0;
    end else if (take) begin
      if (pos_eff == POS_STATUS) begin
        held_status <= in_data.data_byte;
        value_acc   <= 24'd0;
        crc_acc     <= crc_feed(CRC_INIT, in_data.data_byte);
        pos         <= pos_eff + 3'd1;
      end else if (pos_eff < CRC_SPAN) begin
        crc_acc   <= crc_feed(crc_acc, in_data.data_byte);
        value_acc <= {value_acc[15:0], in_data.data_byte};
        pos       <= pos_eff + 3'd1;
      end else begin
        crc_acc <= CRC_INIT;
        pos     <= POS_STATUS;
      end
    end
  end

endmodule

FILE: rtl/vfcc_out_stage.sv
// result register with valid/stall handshake
// depends on vfcc_pkg
module vfcc_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  vfcc_pkg::res_t res,
  output logic           busy,
  output logic           out_valid,
  input  logic           out_stall,
  output vfcc_pkg::out_t out_data
);
  import vfcc_pkg::*;

  // a held result that cannot leave blocks the upstream side
  assign busy = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data <= res.data;
    end
  end

endmodule

FILE: rtl/voc_frame_crc_checker.sv
// voc frame crc checker: one frame byte per transfer, one result per five-byte frame
// the result is in the output register in the cycle after the crc byte transfer
// throughput: one byte per cycle; the crc-8 byte update is a single unrolled step per cycle
// input stalls only while a finished result is held and the output side stalls
// reset (rst, synchronous): frame position 0, crc 0xff, status and value cleared, no result
// depends on vfcc_pkg, vfcc_frame_track, vfcc_out_stage, voc_frame_crc_checker_assert.svh
`include "voc_frame_crc_checker_assert.svh"
module voc_frame_crc_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  vfcc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output vfcc_pkg::out_t out_data
);
  import vfcc_pkg::*;

  logic             take;   // input transfer this cycle
  logic             busy;   // result register full and stalled
  res_t             res;    // result produced by the crc byte
  logic [POS_W-1:0] pos;    // position of the next byte in the frame

  assign in_stall = busy;
  assign take     = in_valid & ~busy;

  // frame tracking, crc and value assembly, result formed combinationally
  vfcc_frame_track u_track (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_data (in_data),
    .res     (res),
    .pos     (pos)
  );

  // result register, frees up as soon as the held result is transferred
  vfcc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // frame position never leaves the five-byte range
  `VFCC_ASSERT_NOW(a_pos_range, 1'b1, pos < FRAME_LEN, "frame position out of range")
  // a crc byte transfer always leaves a result in the output register
  `VFCC_ASSERT_NEXT(a_crc_gives_result, take && !in_data.frame_start && pos == CRC_SPAN,
                    out_valid && pos == POS_STATUS, "crc byte did not produce a result")
  // a result is produced only by an accepted byte
  `VFCC_ASSERT_NOW(a_result_needs_take, res.valid, take, "result without input transfer")
  // a transferred result with nothing new behind it clears the register
  `VFCC_ASSERT_NEXT(a_result_drains, out_valid && !out_stall && !res.valid, !out_valid,
                    "result register kept a transferred result")

endmodule
